FILE: design/barrett_modular_multiplier_macros.svh
// Assertion macros for the Barrett modular multiplier checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BARRETT_MODULAR_MULTIPLIER_MACROS_SVH
`define BARRETT_MODULAR_MULTIPLIER_MACROS_SVH

// Implication checked in the same cycle, masked during reset.
`define BMM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, masked during reset.
`define BMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bmm_pkg.sv
// Shared widths, register indexes and types for the Barrett modular multiplier.
// No dependencies.
package bmm_pkg;

  localparam int DataW     = 64;
  localparam int HalfW     = 32;
  localparam int ProdW     = 128;
  localparam int CfgIdxW   = 8;
  localparam int NumStages = 10;

  localparam logic [CfgIdxW-1:0] CfgIdxModulus    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxMuLow      = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgIdxMuHigh     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgIdxComplement = CfgIdxW'(3);

  // Load enables of the two register stages of a 64x64 multiplier.
  typedef struct packed {
    logic prod;
    logic sum;
  } mul_en_t;

endpackage

FILE: design/bmm_in_if.sv
// Operand channel: valid/ready handshake with two 64-bit multiplicands.
// Depends on bmm_pkg.
interface bmm_in_if import bmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] operand_a;
  logic [DataW-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

FILE: design/bmm_out_if.sv
// Result channel: valid/ready handshake with the 64-bit reduced product.
// Depends on bmm_pkg.
interface bmm_out_if import bmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] product_mod;

  modport source (output valid, output product_mod, input ready);
  modport sink   (input valid, input product_mod, output ready);
endinterface

FILE: design/bmm_mul64.sv
// Two-stage 64x64 -> 128 multiplier built from four 32x32 partial products.
// Depends on bmm_pkg.
module bmm_mul64 import bmm_pkg::*; (
  input  logic             clk,
  input  mul_en_t          en,
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output logic [ProdW-1:0] p
);

  logic [DataW-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [ProdW-1:0] p_r;

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en.prod) begin
      ll_r <= a[HalfW-1:0]     * b[HalfW-1:0];
      lh_r <= a[HalfW-1:0]     * b[DataW-1:HalfW];
      hl_r <= a[DataW-1:HalfW] * b[HalfW-1:0];
      hh_r <= a[DataW-1:HalfW] * b[DataW-1:HalfW];
    end
  end

  // stage 2: column sum
  always_ff @(posedge clk) begin
    if (en.sum) begin
      p_r <= ProdW'(ll_r) + (ProdW'(lh_r) << HalfW) + (ProdW'(hl_r) << HalfW)
           + (ProdW'(hh_r) << DataW);
    end
  end

  assign p = p_r;

endmodule

FILE: design/barrett_modular_multiplier.sv
// Barrett modular multiplier: product_mod = operand_a * operand_b mod modulus.
// Channels: in_ch (sink) carries operand_a/operand_b, out_ch (source) carries
// product_mod; both use valid/ready, a transaction completes when both are high.
// Configuration: cfg_we/cfg_index/cfg_wdata write modulus (0), mu_low (1),
// mu_high (2, bit 0 only) and modulus_complement (3); other indexes are ignored.
// Write configuration only while the pipeline is empty.
// Throughput: one transaction per cycle while out_ch is not stalled, set by the
// ten register stages (three 32x32 multiplier ranks, their sums and the
// reduction adds), each of which can take a new item every cycle.
// Stalls: every stage has a valid bit and loads when it is empty or the stage
// after it moves, so bubbles are squeezed out and in_ch.ready stays high until
// every stage holds an item while out_ch is stalled. Nothing is lost or repeated.
// Reset (rst_n low, synchronous): clears all valid bits and the config registers.
// Depends on bmm_pkg, bmm_in_if, bmm_out_if and bmm_mul64.
module barrett_modular_multiplier import bmm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bmm_in_if.sink             in_ch,
  bmm_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] modulus_r, mu_low_r, complement_r;
  logic             mu_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= '0;
      mu_low_r     <= '0;
      mu_high_r    <= 1'b0;
      complement_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgIdxModulus:    modulus_r    <= cfg_wdata;
        CfgIdxMuLow:      mu_low_r     <= cfg_wdata;
        CfgIdxMuHigh:     mu_high_r    <= cfg_wdata[0];
        CfgIdxComplement: complement_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: stage k loads when empty or when stage k+1 loads.
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] v_r, v_nxt;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_r[NumStages-1] || out_ch.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_ch.valid;
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[NumStages-1];

  // ---------------------------------------------------------------------------
  // Stages 0-1: d = a * b
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] d_s1;

  bmm_mul64 u_mul_ab (
    .clk (clk),
    .en  ('{prod: en[0], sum: en[1]}),
    .a   (in_ch.operand_a),
    .b   (in_ch.operand_b),
    .p   (d_s1)
  );

  // ---------------------------------------------------------------------------
  // Stages 2-3: dh * mu_low and dl * mu_low
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] ph_s3, pl_s3;
  logic [ProdW-1:0] d_s2_r, d_s3_r, d_s4_r, d_s5_r, d_s6_r, d_s7_r;

  bmm_mul64 u_mul_hi (
    .clk (clk),
    .en  ('{prod: en[2], sum: en[3]}),
    .a   (d_s1[ProdW-1:DataW]),
    .b   (mu_low_r),
    .p   (ph_s3)
  );

  bmm_mul64 u_mul_lo (
    .clk (clk),
    .en  ('{prod: en[2], sum: en[3]}),
    .a   (d_s1[DataW-1:0]),
    .b   (mu_low_r),
    .p   (pl_s3)
  );

  // d rides alongside until the d - z subtraction
  always_ff @(posedge clk) begin
    if (en[2]) d_s2_r <= d_s1;
    if (en[3]) d_s3_r <= d_s2_r;
    if (en[4]) d_s4_r <= d_s3_r;
    if (en[5]) d_s5_r <= d_s4_r;
    if (en[6]) d_s6_r <= d_s5_r;
    if (en[7]) d_s7_r <= d_s6_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: carries out of the 2^64 column, partial 2^128 column
  // Stage 5: t = floor(d * mu / 2^128), up to 66 bits
  // ---------------------------------------------------------------------------
  logic [DataW+1:0] col_s4;
  logic [1:0]       carry_s4_r;
  logic [DataW:0]   u_s4_r;
  logic [DataW+1:0] t_s5_r;
  logic [DataW-1:0] dl_term, dh_term;

  assign dl_term = mu_high_r ? d_s3_r[DataW-1:0]     : '0;
  assign dh_term = mu_high_r ? d_s3_r[ProdW-1:DataW] : '0;
  assign col_s4  = (DataW+2)'(pl_s3[ProdW-1:DataW]) + (DataW+2)'(ph_s3[DataW-1:0])
                 + (DataW+2)'(dl_term);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      carry_s4_r <= col_s4[DataW+1:DataW];
      u_s4_r     <= (DataW+1)'(ph_s3[ProdW-1:DataW]) + (DataW+1)'(dh_term);
    end
    if (en[5]) begin
      t_s5_r <= (DataW+2)'(u_s4_r) + (DataW+2)'(carry_s4_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 6-7: z = t * m; the bits of t above 64 add th * m to the high word
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] z_s7;
  logic [DataW-1:0] thm_s6_r, thm_s7_r;

  bmm_mul64 u_mul_tm (
    .clk (clk),
    .en  ('{prod: en[6], sum: en[7]}),
    .a   (t_s5_r[DataW-1:0]),
    .b   (modulus_r),
    .p   (z_s7)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      thm_s6_r <= (t_s5_r[DataW]   ? modulus_r : '0)
                + (t_s5_r[DataW+1] ? {modulus_r[DataW-2:0], 1'b0} : '0);
    end
    if (en[7]) thm_s7_r <= thm_s6_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: d - z, both candidates for the low word
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] frh_s8;
  logic             wrap_s8_r;
  logic [DataW-1:0] fr_a_s8_r, fr_b_s8_r;

  assign frh_s8 = d_s7_r[ProdW-1:DataW] - z_s7[ProdW-1:DataW] - thm_s7_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      wrap_s8_r <= (frh_s8 == DataW'(1));
      fr_a_s8_r <= d_s7_r[DataW-1:0] - z_s7[DataW-1:0];
      fr_b_s8_r <= d_s7_r[DataW-1:0] + complement_r - z_s7[DataW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9 (output register): final conditional subtraction of m
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] fr_s9;
  logic [DataW:0]   sub_s9;
  logic [DataW-1:0] result_r;

  assign fr_s9  = wrap_s8_r ? fr_b_s8_r : fr_a_s8_r;
  assign sub_s9 = {1'b0, fr_s9} - {1'b0, modulus_r};

  always_ff @(posedge clk) begin
    if (en[9]) result_r <= sub_s9[DataW] ? fr_s9 : sub_s9[DataW-1:0];
  end

  assign out_ch.product_mod = result_r;

endmodule

FILE: design/bmm_checker.sv
// Port-level checks for the Barrett modular multiplier, bound to the top level.
// Depends on bmm_pkg and barrett_modular_multiplier_macros.svh.
`include "barrett_modular_multiplier_macros.svh"

module bmm_checker import bmm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] out_product_mod
);

  // a pending result holds until taken
  `BMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `BMM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_product_mod), "result changed while stalled")
  // the pipeline is empty right after reset
  `BMM_ASSERT(a_reset_empty, !$past(rst_n), !out_valid, "result shown right after reset")
  // backpressure only arises from a stalled output
  `BMM_ASSERT(a_bp_cause, !in_ready, out_valid && !out_ready, "input stalled without output stall")

endmodule

bind barrett_modular_multiplier bmm_checker u_bmm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_product_mod (out_ch.product_mod)
);

FILE: sim/barrett_modular_multiplier_test.sv
// Self-checking testbench for barrett_modular_multiplier: random and directed
// operand pairs under several register settings, checked against a predictor.
// Depends on bmm_pkg, bmm_in_if, bmm_out_if and the block itself.
module barrett_modular_multiplier_test;
  import bmm_pkg::*;

  // Slowest correct run: the receiver hold-off plus a full pipe, or a long run of
  // random stalls at 71 percent. Nothing near this many quiet cycles is legal.
  localparam int WatchdogLimit = 5000;
  localparam int HoldOffCycles = 60;
  localparam int ReportLimit   = 10;
  localparam int NumPhases     = 9;

  typedef struct packed {
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [DataW-1:0] product_mod;
  } mod_product_t;

  // Holds its own copy of the four registers and the products still owed.
  class mod_product_scoreboard;
    logic [DataW-1:0] modulus            = '0;
    logic [DataW-1:0] mu_low             = '0;
    logic             mu_high            = 1'b0;
    logic [DataW-1:0] modulus_complement = '0;
    mod_product_t     owed_products[$];
    int               mismatch_count     = 0;

    function void write_register(logic [CfgIdxW-1:0] reg_index, logic [DataW-1:0] value);
      case (reg_index)
        CfgIdxModulus:    modulus = value;
        CfgIdxMuLow:      mu_low = value;
        CfgIdxMuHigh:     mu_high = value[0];
        CfgIdxComplement: modulus_complement = value;
        default: ;
      endcase
    endfunction

    // Barrett datapath: t = floor(d * mu / 2^128), z = t * m, then up to two
    // corrections. Every word wraps, so inconsistent registers are covered too.
    function logic [DataW-1:0] barrett_reduce(logic [DataW-1:0] a, logic [DataW-1:0] b);
      logic [ProdW-1:0] d, dh_mu, dl_mu;
      logic [DataW-1:0] dh, dl, dh_term, dl_term, zh, zl, fr;
      logic [DataW+1:0] mid_col, t;
      logic [ProdW+1:0] z;
      d       = {64'd0, a} * {64'd0, b};
      dh      = d[ProdW-1:DataW];
      dl      = d[DataW-1:0];
      dh_mu   = {64'd0, dh} * {64'd0, mu_low};
      dl_mu   = {64'd0, dl} * {64'd0, mu_low};
      dh_term = mu_high ? dh : '0;
      dl_term = mu_high ? dl : '0;
      // weight 2^64 column only contributes its carries
      mid_col = {2'b0, dl_mu[ProdW-1:DataW]} + {2'b0, dh_mu[DataW-1:0]} + {2'b0, dl_term};
      t       = {2'b0, dh_mu[ProdW-1:DataW]} + {2'b0, dh_term}
                + {64'd0, mid_col[DataW+1:DataW]};
      z       = {64'd0, t} * {66'd0, modulus};
      zh      = z[ProdW-1:DataW];
      zl      = z[DataW-1:0];
      if (dh - zh == 64'd1) begin
        fr = dl + modulus_complement - zl;
      end else begin
        fr = dl - zl;
      end
      if (fr >= modulus) begin
        fr = fr - modulus;
      end
      return fr;
    endfunction

    function void note_operands(logic [DataW-1:0] a, logic [DataW-1:0] b);
      mod_product_t entry;
      entry.operand_a   = a;
      entry.operand_b   = b;
      entry.product_mod = barrett_reduce(a, b);
      owed_products.push_back(entry);
    endfunction

    function void check_product(logic [DataW-1:0] actual);
      mod_product_t entry;
      if (owed_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("%0t: result %h arrived with nothing outstanding", $time, actual);
        end
        return;
      end
      entry = owed_products.pop_front();
      if (actual !== entry.product_mod) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("%0t: a=%h b=%h product_mod expected %h got %h", $time,
                   entry.operand_a, entry.operand_b, entry.product_mod, actual);
        end
      end
    endfunction

    function int outstanding();
      return owed_products.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_wdata;

  bmm_in_if  in_ch();
  bmm_out_if out_ch();

  mod_product_scoreboard scoreboard = new();

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  bit hold_off_request   = 1'b0;
  int quiet_cycles       = 0;

  barrett_modular_multiplier u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly reduced operands when m is nonzero; the rest are edge values or anything at all.
  function automatic logic [DataW-1:0] choose_operand(logic [DataW-1:0] m);
    int               kind;
    logic [DataW-1:0] r;
    kind = $urandom_range(99);
    r    = rand64();
    if (kind < 70 && m != '0) begin
      return r % m;
    end else if (kind < 85) begin
      case ($urandom_range(4))
        0:       return '0;
        1:       return 64'd1;
        2:       return m - 64'd1;
        3:       return m;
        default: return '1;
      endcase
    end
    return r;
  endfunction

  // One input transaction; random gaps before it, returns at the accepting edge.
  task automatic send_operands(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Result side: random stalls, plus a long hold-off on request so that the
  // pipe fills and in_ch.ready has to drop.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_request && rst_n) begin
        hold_off_request = 1'b0;
        repeat (HoldOffCycles) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        @(posedge clk);
      end
    end
  end

  // Samples at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_we) begin
        scoreboard.write_register(cfg_index, cfg_wdata);
        quiet_cycles = 0;
      end
      if (in_ch.valid && in_ch.ready) begin
        scoreboard.note_operands(in_ch.operand_a, in_ch.operand_b);
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        scoreboard.check_product(out_ch.product_mod);
        quiet_cycles = 0;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
    $display("FAIL barrett_modular_multiplier");
    $finish;
  end

  initial begin
    logic [DataW-1:0]   m, mu_lo, mu_hi_word, comp;
    logic [ProdW:0]     mu_full;
    logic [CfgIdxW-1:0] write_idx [5];
    logic [DataW-1:0]   write_val [5];

    in_ch.valid     <= 1'b0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 0 keeps the reset registers (zero modulus); later phases load a
    // new setting each. Idle modes rotate: none, sender, receiver, both.
    for (int k = 0; k < NumPhases; k++) begin
      case (k % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          hold_off_request   = 1'b1;
        end
        1: begin
          sender_idle_pct    = 71;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 71;
        end
        default: begin
          sender_idle_pct    = 32;
          receiver_stall_pct = 32;
        end
      endcase

      if (k != 0) begin
        case (k)
          1:       m = '1;                              // largest modulus
          2:       m = (64'd1 << 63) | 64'd1;           // smallest with mu in 65 bits
          4:       m = 64'd1 << 63;                     // mu overflows 65 bits
          5: begin                                      // small modulus, mu truncated
            m = rand64() >> $urandom_range(62, 1);
            if (m == '0) begin
              m = 64'd3;
            end
          end
          7:       m = '0;
          default: m = rand64() | (64'd1 << 63);
        endcase
        if (m != '0) begin
          mu_full = (129'd1 << 128) / {65'd0, m};
        end else begin
          mu_full = '0;
        end
        mu_lo      = mu_full[DataW-1:0];
        mu_hi_word = {63'd0, mu_full[DataW]};
        comp       = -m;
        case (k)
          6: begin                                      // inconsistent registers
            mu_lo      = rand64();
            mu_hi_word = rand64();
            comp       = rand64();
          end
          7: begin                                      // zero modulus, rest all ones
            mu_lo      = '1;
            mu_hi_word = '1;
            comp       = '1;
          end
          8:       mu_hi_word = mu_full[DataW] ? '1 : 64'hffff_ffff_ffff_fffe;
          default: ;
        endcase

        // an out-of-range index first; the block must drop it
        write_idx[0] = CfgIdxW'($urandom_range(255, 4));
        write_val[0] = rand64();
        write_idx[1] = CfgIdxModulus;
        write_val[1] = m;
        write_idx[2] = CfgIdxMuLow;
        write_val[2] = mu_lo;
        write_idx[3] = CfgIdxMuHigh;
        write_val[3] = mu_hi_word;
        write_idx[4] = CfgIdxComplement;
        write_val[4] = comp;
        for (int w = 0; w < 5; w++) begin
          cfg_we    <= 1'b1;
          cfg_index <= write_idx[w];
          cfg_wdata <= write_val[w];
          @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
      end

      // directed edge cases
      if (k == 0) begin
        send_operands('0, '0);
        send_operands('1, '1);
        send_operands(64'd1, '1);
        send_operands('1, 64'd1);
      end else if (k == 1) begin
        send_operands('0, '0);
        send_operands(64'd1, 64'd1);
        send_operands(m - 64'd1, m - 64'd1);
        send_operands(m - 64'd1, 64'd2);
        send_operands('1, '1);                          // both equal to the modulus
        send_operands('1, '0);
        send_operands(64'd1 << 63, 64'd2);
        send_operands(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_operands(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_operands(64'd1, m - 64'd1);
      end else if (k == 2) begin
        send_operands(m - 64'd1, m - 64'd1);
        send_operands(m, m);
        send_operands('1, '1);
        send_operands(m, 64'd1);
      end

      repeat ((k == 0) ? 100 : 215) begin
        send_operands(choose_operand(scoreboard.modulus), choose_operand(scoreboard.modulus));
      end

      // drain before the next register load
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (scoreboard.outstanding() != 0) @(posedge clk);
      repeat (NumStages + 2) @(posedge clk);
    end

    if (scoreboard.outstanding() != 0) begin
      $display("%0d expected results never arrived", scoreboard.outstanding());
    end
    if (scoreboard.mismatch_count == 0 && scoreboard.outstanding() == 0) begin
      $display("PASS barrett_modular_multiplier");
    end else begin
      $display("FAIL barrett_modular_multiplier");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/bmm_pkg.sv
design/bmm_in_if.sv
design/bmm_out_if.sv
design/bmm_mul64.sv
design/barrett_modular_multiplier.sv
design/bmm_checker.sv
sim/barrett_modular_multiplier_test.sv
